>>> hw/rtl/ptfew_pkg.sv
`default_nettype none
package ptfew_pkg;

	// request and result payloads
	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        subject_pid;
		logic [15:0]        target_child;
		logic               any_child;
		logic signed [15:0] exit_code;
	} req_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic [15:0]        new_pid;
		logic signed [15:0] reaped_code;
		logic               woke_parent;
	} res_t;

	// command codes
	localparam logic [1:0] CMD_FORK = 2'd0;
	localparam logic [1:0] CMD_EXIT = 2'd1;
	localparam logic [1:0] CMD_WAIT = 2'd2;
	localparam logic [1:0] CMD_KILL = 2'd3;

	// outcome codes
	localparam logic [1:0] OUT_DONE    = 2'd0;
	localparam logic [1:0] OUT_FULL    = 2'd1;
	localparam logic [1:0] OUT_NOPAR   = 2'd2;
	localparam logic [1:0] OUT_BLOCKED = 2'd3;

	// slot states
	localparam logic [2:0] ST_EMPTY      = 3'd0;
	localparam logic [2:0] ST_RUNNING    = 3'd1;
	localparam logic [2:0] ST_BLOCKED    = 3'd2;
	localparam logic [2:0] ST_ZOMBIE     = 3'd3;
	localparam logic [2:0] ST_TERMINATED = 3'd4;

	localparam logic [6:0] CHILD_MAX = 7'd127;

	// scan kinds
	localparam logic [1:0] SC_FORK   = 2'd0;
	localparam logic [1:0] SC_SUBJ   = 2'd1;
	localparam logic [1:0] SC_PAR    = 2'd2;
	localparam logic [1:0] SC_ZOMBIE = 2'd3;

	// write kinds
	localparam logic [2:0] WR_CLEAR   = 3'd0;
	localparam logic [2:0] WR_NEWSLOT = 3'd1;
	localparam logic [2:0] WR_INC     = 3'd2;
	localparam logic [2:0] WR_EXIT    = 3'd3;
	localparam logic [2:0] WR_WAKE    = 3'd4;
	localparam logic [2:0] WR_REAP    = 3'd5;
	localparam logic [2:0] WR_BLOCK   = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic       take_req;
		logic       scan_start;
		logic [1:0] scan_kind;
		logic       rd_en;
		logic       cnt_inc;
		logic       wr_en;
		logic [2:0] wr_kind;
		logic       set_out;
		logic [1:0] out_code;
		logic       load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       clr_last;
		logic       scan_done;
		logic       fork_ok;
		logic       b_found;
		logic       wait_ok;
		logic       z_found;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/ptfew_ram.sv
`default_nettype none
module ptfew_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/ptfew_ctrl.sv
`default_nettype none
module ptfew_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire ptfew_pkg::stat_t st,
	output ptfew_pkg::cmd_t     cmd
);
	import ptfew_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ST1  = 4'd2;
	localparam logic [3:0] S_SC1  = 4'd3;
	localparam logic [3:0] S_DEC1 = 4'd4;
	localparam logic [3:0] S_INC  = 4'd5;
	localparam logic [3:0] S_ST2  = 4'd6;
	localparam logic [3:0] S_SC2  = 4'd7;
	localparam logic [3:0] S_DEC2 = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// sequencing of scans and slot writes
	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_kind = WR_CLEAR;
				cmd.cnt_inc = 1'b1;
				if (st.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.take_req = 1'b1;
					state_nxt = S_ST1;
				end
			end
			S_ST1: begin
				cmd.scan_start = 1'b1;
				cmd.scan_kind = (st.command == CMD_FORK) ? SC_FORK : SC_SUBJ;
				state_nxt = S_SC1;
			end
			S_SC1: begin
				cmd.rd_en = 1'b1;
				if (st.scan_done) state_nxt = S_DEC1;
			end
			S_DEC1: begin
				case (st.command)
					CMD_FORK: begin
						if (st.fork_ok) begin
							cmd.wr_en = 1'b1;
							cmd.wr_kind = WR_NEWSLOT;
							state_nxt = S_INC;
						end else begin
							cmd.set_out = 1'b1;
							cmd.out_code = OUT_FULL;
							state_nxt = S_DONE;
						end
					end
					CMD_WAIT: begin
						if (st.wait_ok) begin
							state_nxt = S_ST2;
						end else begin
							cmd.set_out = 1'b1;
							cmd.out_code = OUT_NOPAR;
							state_nxt = S_DONE;
						end
					end
					default: begin
						if (st.b_found) begin
							cmd.wr_en = 1'b1;
							cmd.wr_kind = WR_EXIT;
							state_nxt = S_ST2;
						end else begin
							state_nxt = S_DONE;
						end
					end
				endcase
			end
			S_INC: begin
				cmd.wr_en = 1'b1;
				cmd.wr_kind = WR_INC;
				state_nxt = S_DONE;
			end
			S_ST2: begin
				cmd.scan_start = 1'b1;
				cmd.scan_kind = (st.command == CMD_WAIT) ? SC_ZOMBIE : SC_PAR;
				state_nxt = S_SC2;
			end
			S_SC2: begin
				cmd.rd_en = 1'b1;
				if (st.scan_done) state_nxt = S_DEC2;
			end
			S_DEC2: begin
				cmd.wr_en = 1'b1;
				if (st.command == CMD_WAIT) begin
					cmd.wr_kind = st.z_found ? WR_REAP : WR_BLOCK;
				end else begin
					cmd.wr_kind = WR_WAKE;
				end
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// a request is only taken when the table is idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_req |-> state_q == S_IDLE)
		else $error("request taken outside idle");
	// a result is loaded only at the end of a command
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == S_IDLE && $past(state_q) == S_DONE)
		else $error("result loaded out of sequence");
	// the clearing pass ends before any request
	a_clr_first: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> req_stall && !cmd.take_req)
		else $error("request during clearing pass");
endmodule
`default_nettype wire

>>> hw/rtl/ptfew_dp.sv
`default_nettype none
module ptfew_dp #(
	parameter int TABLE_SLOTS = 64,
	parameter int PID_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptfew_pkg::req_t   req_data,
	input  wire logic              res_stall,
	output logic                   res_valid,
	output ptfew_pkg::res_t        res_data,
	input  wire ptfew_pkg::cmd_t   cmd,
	output ptfew_pkg::stat_t       st
);
	import ptfew_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int P = PID_BITS;
	localparam int CW = (P > 16) ? P : 16;
	localparam int CODE_LO = 7;
	localparam int PAR_LO = 23;
	localparam int PID_LO = 23 + P;
	localparam int ST_LO = 23 + 2 * P;
	localparam int RW = 26 + 2 * P;
	localparam logic [AW:0] SLOTS = (AW + 1)'(TABLE_SLOTS);
	localparam logic [AW:0] LAST = (AW + 1)'(TABLE_SLOTS - 1);

	req_t        req_q;
	res_t        res_q;
	res_t        out_q;
	logic        out_valid_q;
	logic [P-1:0] pidc_q;
	logic [AW:0] cnt_q;
	logic        rd_v_s1;
	logic [AW-1:0] idx_s1;
	logic [1:0]  kind_q;
	logic [CW-1:0] key_q;
	logic        a_found_q, b_found_q, z_found_q;
	logic [AW-1:0] a_idx_q, b_idx_q, z_idx_q;
	logic [RW-1:0] b_rec_q, z_rec_q;
	logic [RW-1:0] rd_data;
	logic        issue;
	logic        we;
	logic [AW-1:0] waddr;
	logic [RW-1:0] wdata;

	// fields of the slot being read and of the captured match
	logic [2:0]    r_st;
	logic [P-1:0]  r_pid, r_par;
	logic [2:0]    b_st;
	logic [P-1:0]  b_par;
	logic [6:0]    b_ch;
	logic [CW-1:0] subj_x, targ_x;
	logic          hit_a, hit_b, hit_z;

	assign r_st = rd_data[ST_LO +: 3];
	assign r_pid = rd_data[PID_LO +: P];
	assign r_par = rd_data[PAR_LO +: P];
	assign b_st = b_rec_q[ST_LO +: 3];
	assign b_par = b_rec_q[PAR_LO +: P];
	assign b_ch = b_rec_q[6:0];
	assign subj_x = CW'(req_q.subject_pid);
	assign targ_x = CW'(req_q.target_child);

	ptfew_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	// slot scan: one read issued per cycle
	assign issue = cmd.rd_en && (cnt_q < SLOTS);

	assign hit_a = rd_v_s1 && !a_found_q && kind_q == SC_FORK && r_st == ST_EMPTY;
	assign hit_b = rd_v_s1 && !b_found_q && kind_q != SC_ZOMBIE && r_st != ST_EMPTY
		&& CW'(r_pid) == key_q;
	assign hit_z = rd_v_s1 && !z_found_q && kind_q == SC_ZOMBIE && r_st == ST_ZOMBIE
		&& CW'(r_par) == subj_x && (req_q.any_child || CW'(r_pid) == targ_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			a_found_q <= 1'b0;
			b_found_q <= 1'b0;
			z_found_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd.scan_start) begin
				cnt_q <= '0;
				a_found_q <= 1'b0;
				if (cmd.scan_kind != SC_ZOMBIE) b_found_q <= 1'b0;
				z_found_q <= 1'b0;
			end else begin
				if (cmd.cnt_inc || issue) cnt_q <= cnt_q + 1'b1;
				if (hit_a) a_found_q <= 1'b1;
				if (hit_b) b_found_q <= 1'b1;
				if (hit_z) z_found_q <= 1'b1;
			end
		end
	end

	// scan key and first-match captures
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (cmd.scan_start) begin
			kind_q <= cmd.scan_kind;
			key_q <= (cmd.scan_kind == SC_PAR) ? CW'(b_par) : subj_x;
		end
		if (hit_a) a_idx_q <= idx_s1;
		if (hit_b) begin
			b_idx_q <= idx_s1;
			b_rec_q <= rd_data;
		end
		if (hit_z) begin
			z_idx_q <= idx_s1;
			z_rec_q <= rd_data;
		end
	end

	// slot write port
	always_comb begin
		we = cmd.wr_en;
		waddr = b_idx_q;
		wdata = b_rec_q;
		case (cmd.wr_kind)
			WR_CLEAR: begin
				waddr = cnt_q[AW-1:0];
				if (cnt_q == '0) begin
					wdata = {ST_RUNNING, P'(1), P'(0), 16'hFFFF, 7'd0};
				end else begin
					wdata = {ST_EMPTY, P'(0), P'(0), 16'hFFFF, 7'd0};
				end
			end
			WR_NEWSLOT: begin
				waddr = a_idx_q;
				wdata = {ST_RUNNING, pidc_q, P'(req_q.subject_pid), 16'hFFFF, 7'd0};
			end
			WR_INC: begin
				we = cmd.wr_en && b_found_q && b_ch < CHILD_MAX;
				wdata[6:0] = b_ch + 7'd1;
			end
			WR_EXIT: begin
				wdata[ST_LO +: 3] = ST_ZOMBIE;
				wdata[CODE_LO +: 16] = (req_q.command == CMD_EXIT) ? req_q.exit_code : 16'd0;
			end
			WR_WAKE: begin
				we = cmd.wr_en && b_found_q && b_st == ST_BLOCKED;
				wdata[ST_LO +: 3] = ST_RUNNING;
			end
			WR_REAP: begin
				waddr = z_idx_q;
				wdata = z_rec_q;
				wdata[ST_LO +: 3] = ST_TERMINATED;
			end
			WR_BLOCK: begin
				wdata[ST_LO +: 3] = ST_BLOCKED;
			end
			default: we = 1'b0;
		endcase
	end

	// request, pid counter, result build and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidc_q <= P'(2);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_en && cmd.wr_kind == WR_NEWSLOT) pidc_q <= pidc_q + 1'b1;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			req_q <= req_data;
			res_q <= '0;
		end else begin
			if (cmd.set_out) res_q.outcome <= cmd.out_code;
			if (cmd.wr_en && cmd.wr_kind == WR_NEWSLOT) res_q.new_pid <= 16'(pidc_q);
			if (we && cmd.wr_kind == WR_WAKE) res_q.woke_parent <= 1'b1;
			if (cmd.wr_en && cmd.wr_kind == WR_REAP) begin
				res_q.reaped_code <= z_rec_q[CODE_LO +: 16];
			end
			if (cmd.wr_en && cmd.wr_kind == WR_BLOCK) res_q.outcome <= OUT_BLOCKED;
		end
		if (cmd.load_out) out_q <= res_q;
	end

	assign res_valid = out_valid_q;
	assign res_data = out_q;

	// status to the controller
	assign st.command = req_q.command;
	assign st.clr_last = (cnt_q == LAST);
	assign st.scan_done = (cnt_q == SLOTS) && !rd_v_s1;
	assign st.fork_ok = a_found_q && pidc_q != '0;
	assign st.b_found = b_found_q;
	assign st.wait_ok = b_found_q && b_ch != 7'd0;
	assign st.z_found = z_found_q;
	assign st.out_free = !out_valid_q || !res_stall;

	// writes never land while scan reads are in flight
	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && rd_v_s1))
		else $error("slot write during scan");
	// a blocked answer carries no pid and no reaped code
	a_blk_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && res_q.outcome == OUT_BLOCKED |->
		res_q.new_pid == 16'd0 && res_q.reaped_code == 16'sd0)
		else $error("blocked result carries data");
	// each new slot moves the pid counter on
	a_pid_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && cmd.wr_kind == WR_NEWSLOT |=> pidc_q != $past(pidc_q))
		else $error("pid counter did not advance");
endmodule
`default_nettype wire

>>> hw/rtl/process_table_fork_exit_wait.sv
// channel   handshake              payload    direction
// request   req_valid / req_stall  req_data   in
// result    res_valid / res_stall  res_data   out
//
// fork runs one scan of the table, which finds the first free slot and the parent together.
// exit, kill and wait run up to two scans: a second scan finds the parent or the zombie child.
// the slot memory has one read port, read one slot per cycle. after reset a clearing pass
// writes every slot; no request is taken meanwhile. a stalled result sits in the output
// register and the next request is taken while it waits; a finished command then holds until
// that register is free.
`default_nettype none
module process_table_fork_exit_wait #(
	parameter int TABLE_SLOTS = 64,
	parameter int PID_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire ptfew_pkg::req_t   req_data,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output ptfew_pkg::res_t        res_data
);
	import ptfew_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer
	ptfew_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// slot table and result path
	ptfew_dp #(.TABLE_SLOTS(TABLE_SLOTS), .PID_BITS(PID_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_data  (res_data),
		.cmd       (cmd),
		.st        (st)
	);
endmodule
`default_nettype wire
